@@ rtl/core/redt_pkg.sv @@
// redt_pkg: shared types, constants and helpers for the detent tracker
// used by redt_div and rotary_encoder_detent_tracker_top; no dependencies

package redt_pkg;

    // field widths
    localparam int CNT_W  = 16;   // hardware quadrature counter
    localparam int POS_W  = 32;   // pulse accumulator and detent count
    localparam int PPD_W  = 8;    // pulses per detent register
    localparam int CMD_W  = 3;
    localparam int DIR_W  = 2;
    localparam int FLAG_W = 3;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 32;

    // stream word widths
    localparam int IN_DATA_W  = CNT_W + 2 * POS_W;
    localparam int OUT_BITS   = 4 * POS_W + 1 + FLAG_W + DIR_W + 1 + CNT_W - POS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    // divider sequencing
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // counter wrap correction, delta is CNT_W+1 bits signed
    localparam logic signed [CNT_W:0] DELTA_HI = (CNT_W + 1)'((2 ** (CNT_W - 1)) - 1);
    localparam logic signed [CNT_W:0] DELTA_LO = -DELTA_HI;
    localparam logic [CNT_W:0]        CNT_SPAN = (CNT_W + 1)'(1) << CNT_W;

    // direction codes
    localparam logic signed [DIR_W-1:0] DIR_UP   = DIR_W'(1);
    localparam logic signed [DIR_W-1:0] DIR_DOWN = -DIR_W'(1);
    localparam logic signed [DIR_W-1:0] DIR_NONE = DIR_W'(0);

    // sticky flag bits
    localparam int FLAG_CHANGED = 0;
    localparam int FLAG_UP      = 1;
    localparam int FLAG_DOWN    = 2;

    // reset values of the configuration registers
    localparam logic [PPD_W-1:0]        PPD_RESET = PPD_W'(4);
    localparam logic signed [POS_W-1:0] MIN_RESET = {1'b1, {(POS_W - 1){1'b0}}};
    localparam logic signed [POS_W-1:0] MAX_RESET = {1'b0, {(POS_W - 1){1'b1}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL      = 3'd0,
        CMD_SET       = 3'd1,
        CMD_ADD       = 3'd2,
        CMD_INVERT    = 3'd3,
        CMD_RESET_MIN = 3'd4,
        CMD_RESTART   = 3'd5
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_PPD  = 2'd0,
        REG_SWAP = 2'd1,
        REG_MIN  = 2'd2,
        REG_MAX  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CLAMP,
        ST_APPLY,
        ST_RELOAD,
        ST_RESTART,
        ST_DONE
    } t_state;

    // divider request and response
    typedef struct packed {
        logic                     start;
        logic signed [POS_W-1:0]  dividend;
        logic [PPD_W-1:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [POS_W-1:0]  quotient;
    } t_div_rsp;

    // a zero divisor behaves as one
    function automatic logic [PPD_W-1:0] eff_divisor(input logic [PPD_W-1:0] ppd);
        eff_divisor = (ppd == '0) ? PPD_W'(1) : ppd;
    endfunction

endpackage

@@ rtl/core/rotary_encoder_detent_tracker_top.sv @@
// rotary_encoder_detent_tracker_top: quadrature position counter with detent scaling
// sequencer, state registers and output register; uses redt_pkg and redt_div
//
//  channel   direction  handshake                    content
//  s_axis    in         s_axis_tvalid/s_axis_tready  command in tuser, sample/operand/tick
//  m_axis    out        m_axis_tvalid/m_axis_tready  count, position, flags, load request
//  cfg       in         i_cfg_valid/o_cfg_ready      register index and write data
//
// one word at a time; each word makes one pass of the shared divider, add and invert
// two since they divide before and after the reload
// synchronous active-low reset clears tracker state, config registers to defaults
// a finished result waits in the output register; the next word is taken meanwhile
// and held in its last step until the output register is free
// cfg always ready; the user writes it only while no word is in flight (unenforced)

module rotary_encoder_detent_tracker_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] counter_sample, [47:16] operand_value, [79:48] tick_now
    input  logic [redt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [2:0] command
    input  logic [redt_pkg::CMD_W-1:0]       s_axis_tuser,
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] detent_count, [63:32] pulse_position, [64] count_changed,
    // [67:65] event_flags, [69:68] last_direction, [101:70] activity_tick,
    // [102] counter_load, [118:103] counter_load_value, [119] zero
    output logic [redt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [redt_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [redt_pkg::CFG_W-1:0]       i_cfg_data
);
    import redt_pkg::*;

    // configuration registers
    logic [PPD_W-1:0]          r_ppd;
    logic                      r_swap;
    logic signed [POS_W-1:0]   r_min;
    logic signed [POS_W-1:0]   r_max;

    // tracker state
    logic [POS_W-1:0]          r_acc;
    logic [CNT_W-1:0]          r_base;
    logic signed [POS_W-1:0]   r_reported;
    logic [FLAG_W-1:0]         r_flags;
    logic signed [DIR_W-1:0]   r_dir;
    logic [POS_W-1:0]          r_tick_chg;

    // sequencer and per-word registers
    t_state                    r_state;
    t_state                    n_state;
    t_cmd                      r_cmd;
    logic [CNT_W-1:0]          r_sample;
    logic signed [POS_W-1:0]   r_operand;
    logic [POS_W-1:0]          r_tick;
    logic signed [POS_W-1:0]   r_value;
    logic signed [POS_W-1:0]   r_count;
    logic                      r_final;
    logic                      r_changed;
    logic                      r_load;
    logic [CNT_W-1:0]          r_load_value;

    // output register
    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;

    // handshakes and strobes
    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_out_load;
    logic                      w_in_ready;
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;

    // datapath helpers
    logic [POS_W-1:0]          w_position;
    logic signed [CNT_W:0]     w_delta_raw;
    logic [CNT_W:0]            w_delta;
    logic signed [POS_W-1:0]   w_clamped;
    logic [PPD_W-1:0]          w_eff;
    logic signed [POS_W+PPD_W:0] w_prod;
    logic [POS_W-1:0]          w_reload;

    assign w_in_acc   = s_axis_tvalid && w_in_ready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppd  <= PPD_RESET;
            r_swap <= 1'b0;
            r_min  <= MIN_RESET;
            r_max  <= MAX_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PPD:  r_ppd  <= i_cfg_data[PPD_W-1:0];
                REG_SWAP: r_swap <= i_cfg_data[0];
                REG_MIN:  r_min  <= $signed(i_cfg_data[POS_W-1:0]);
                REG_MAX:  r_max  <= $signed(i_cfg_data[POS_W-1:0]);
                default:  r_ppd  <= r_ppd;
            endcase
        end
    end

    // reported position, negated when the direction is swapped
    assign w_position = r_swap ? (POS_W'(0) - r_acc) : r_acc;

    // counter change since the baseline, corrected for counter wrap
    always_comb begin
        w_delta_raw = $signed({r_sample[CNT_W-1], r_sample})
                    - $signed({r_base[CNT_W-1], r_base});
        w_delta     = w_delta_raw;
        if (w_delta_raw > DELTA_HI) begin
            w_delta = w_delta_raw - CNT_SPAN;
        end
        // a change of exactly half the span ends positive either way
        if ($signed(w_delta) < DELTA_LO) begin
            w_delta = w_delta + CNT_SPAN;
        end
    end

    // clamp of the quotient; crossed limits end on the upper one
    always_comb begin
        w_clamped = w_div_rsp.quotient;
        if (w_clamped < r_min) begin
            w_clamped = r_min;
        end
        if (w_clamped > r_max) begin
            w_clamped = r_max;
        end
    end

    // reload: value times divisor, negated under swap, wrapped to the position width
    always_comb begin
        w_eff    = eff_divisor(r_ppd);
        w_prod   = r_value * $signed({1'b0, w_eff});
        w_reload = r_swap ? (POS_W'(0) - w_prod[POS_W-1:0]) : w_prod[POS_W-1:0];
    end

    // shared divider
    redt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (t_cmd'(s_axis_tuser))
                        CMD_POLL, CMD_ADD, CMD_INVERT: n_state = ST_SAMPLE;
                        CMD_SET, CMD_RESET_MIN:        n_state = ST_RELOAD;
                        CMD_RESTART:                   n_state = ST_RESTART;
                        default:                       n_state = ST_DIV_START;
                    endcase
                end
            end
            ST_SAMPLE:    n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP:     n_state = ST_APPLY;
            ST_APPLY: begin
                if (!r_final && (r_cmd == CMD_ADD || r_cmd == CMD_INVERT)) begin
                    n_state = ST_RELOAD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RELOAD:    n_state = ST_DIV_START;
            ST_RESTART:   n_state = ST_DIV_START;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_in_ready         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = $signed(w_position);
        w_div_req.divisor  = r_ppd;
        w_out_load         = 1'b0;
        case (r_state)
            ST_IDLE:      w_in_ready      = 1'b1;
            ST_DIV_START: w_div_req.start = 1'b1;
            ST_DONE:      w_out_load      = w_out_free;
            default:      w_in_ready      = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // word capture and per-step datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_base     <= '0;
            r_reported <= '0;
            r_flags    <= '0;
            r_dir      <= DIR_NONE;
            r_tick_chg <= '0;
            r_final    <= 1'b0;
            r_changed  <= 1'b0;
            r_load     <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd        <= t_cmd'(s_axis_tuser);
                        r_sample     <= s_axis_tdata[CNT_W-1:0];
                        r_operand    <= $signed(s_axis_tdata[CNT_W+POS_W-1:CNT_W]);
                        r_tick       <= s_axis_tdata[CNT_W+2*POS_W-1:CNT_W+POS_W];
                        r_value      <= (t_cmd'(s_axis_tuser) == CMD_RESET_MIN) ? r_min
                                      : $signed(s_axis_tdata[CNT_W+POS_W-1:CNT_W]);
                        r_final      <= 1'b0;
                        r_changed    <= 1'b0;
                        r_load       <= 1'b0;
                        r_load_value <= '0;
                    end
                end
                // fold the counter change into the accumulator
                ST_SAMPLE: begin
                    r_base <= r_sample;
                    r_acc  <= r_acc + {{(POS_W - CNT_W - 1){w_delta[CNT_W]}}, w_delta};
                end
                ST_CLAMP: begin
                    r_count <= w_clamped;
                end
                ST_APPLY: begin
                    if (r_final) begin
                        r_reported <= r_count;
                    end else begin
                        case (r_cmd)
                            // poll: record a new count with its direction and tick
                            CMD_POLL: begin
                                if (r_count != r_reported) begin
                                    r_changed  <= 1'b1;
                                    r_reported <= r_count;
                                    r_tick_chg <= r_tick;
                                    r_flags[FLAG_CHANGED] <= 1'b1;
                                    if (r_count > r_reported) begin
                                        r_flags[FLAG_UP] <= 1'b1;
                                        r_dir            <= DIR_UP;
                                    end else begin
                                        r_flags[FLAG_DOWN] <= 1'b1;
                                        r_dir              <= DIR_DOWN;
                                    end
                                end
                            end
                            CMD_ADD:    r_value <= r_count + r_operand;
                            CMD_INVERT: r_value <= POS_W'(0) - r_count;
                            default:    r_value <= r_value;
                        endcase
                    end
                end
                ST_RELOAD: begin
                    r_acc        <= w_reload;
                    r_base       <= w_reload[CNT_W-1:0];
                    r_flags      <= '0;
                    r_load       <= 1'b1;
                    r_load_value <= w_reload[CNT_W-1:0];
                    r_final      <= 1'b1;
                end
                ST_RESTART: begin
                    r_acc        <= '0;
                    r_base       <= '0;
                    r_flags      <= '0;
                    r_dir        <= DIR_NONE;
                    r_tick_chg   <= '0;
                    r_load       <= 1'b1;
                    r_load_value <= '0;
                    r_final      <= 1'b1;
                end
                default: begin
                    r_final <= r_final;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, r_load_value, r_load, r_tick_chg, r_dir,
                           r_flags, r_changed, w_position, r_count};
        end
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ rtl/core/redt_div.sv @@
// redt_div: shared restoring divider, signed position by unsigned divisor
// one quotient bit per cycle, truncates toward zero; depends on redt_pkg

module redt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  redt_pkg::t_div_req i_req,
    output redt_pkg::t_div_rsp o_rsp
);
    import redt_pkg::*;

    logic                  r_busy;
    logic                  r_fix;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_neg;
    logic [PPD_W-1:0]      r_div;
    logic [PPD_W-1:0]      r_rem;
    logic [POS_W-1:0]      r_quo;
    logic signed [POS_W-1:0] r_result;

    logic [PPD_W:0]        w_trial;
    logic                  w_ge;
    logic [PPD_W:0]        w_diff;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        w_trial = {r_rem, r_quo[POS_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_fix  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: magnitude in, quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[POS_W-1];
            r_quo <= i_req.dividend[POS_W-1] ? (POS_W'(0) - i_req.dividend) : i_req.dividend;
            r_rem <= '0;
            r_div <= eff_divisor(i_req.divisor);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[PPD_W-1:0] : w_trial[PPD_W-1:0];
            r_quo <= {r_quo[POS_W-2:0], w_ge};
        end else if (r_fix) begin
            r_result <= r_neg ? $signed(POS_W'(0) - r_quo) : $signed(r_quo);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_result;

endmodule

@@ verif/tb_rotary_encoder_detent_tracker_top.sv @@
// tb_rotary_encoder_detent_tracker_top: self-checking bench for the detent tracker, directed
// words then random encoder motion under several register settings and stall mixes
// depends on redt_pkg and rotary_encoder_detent_tracker_top
`timescale 1ns / 100ps

module tb_rotary_encoder_detent_tracker_top;
    import redt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int WRAP_HALF = 32767;
    localparam int WRAP_SPAN = 65536;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [15:0]      sample;
        logic [31:0]      operand;
        logic [31:0]      tick;
    } t_tracker_cmd;

    typedef struct {
        logic [31:0] count;
        logic [31:0] position;
        logic        changed;
        logic [2:0]  flags;
        logic [1:0]  dir;
        logic [31:0] tick;
        logic        load;
        logic [15:0] load_value;
    } t_tracker_report;

    // dut ports, all inputs known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    rotary_encoder_detent_tracker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // tracker state as the block should hold it
    logic [7:0]         cfg_ppd = PPD_RESET;
    logic               cfg_swap = 1'b0;
    logic signed [31:0] cfg_min = MIN_RESET;
    logic signed [31:0] cfg_max = MAX_RESET;
    logic [31:0]        trk_acc = '0;
    logic [15:0]        trk_base = '0;
    logic signed [31:0] trk_shown = '0;
    logic [2:0]         trk_flags = '0;
    logic signed [1:0]  trk_dir = DIR_NONE;
    logic [31:0]        trk_tick = '0;

    t_tracker_cmd    pending_cmds[$];
    t_tracker_report expected_reports[$];
    t_tracker_cmd    held_cmd;

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int cmds_issued = 0;
    int results_seen = 0;
    int mismatches = 0;
    int count_changes = 0;
    int reg_writes = 0;
    int cycle_count = 0;
    int cmd_seen[8] = '{default: 0};

    // stimulus-side view of the hardware counter and tick
    logic [15:0] stim_counter = '0;
    logic [31:0] stim_tick = '0;

    function automatic logic [31:0] ppd_divisor();
        return (cfg_ppd == 8'd0) ? 32'd1 : {24'd0, cfg_ppd};
    endfunction

    function automatic logic [31:0] shown_position();
        return cfg_swap ? -trk_acc : trk_acc;
    endfunction

    // position over pulses per detent, truncated, then min clamp and max clamp
    function automatic logic signed [31:0] clamped_detents();
        longint q;
        q = longint'($signed(shown_position())) / longint'(ppd_divisor());
        if (q < longint'(cfg_min)) q = cfg_min;
        if (q > longint'(cfg_max)) q = cfg_max;
        return q[31:0];
    endfunction

    // take the wrap-corrected counter change into the accumulator
    function automatic void take_counter(input logic [15:0] sample);
        int d;
        d = int'($signed(sample)) - int'($signed(trk_base));
        if (d > WRAP_HALF) d -= WRAP_SPAN;
        if (d < -WRAP_HALF) d += WRAP_SPAN;
        trk_base = sample;
        trk_acc = trk_acc + 32'(d);
    endfunction

    // load the accumulator from a detent count, returns the counter load value
    function automatic logic [15:0] reload_count(input logic [31:0] value);
        logic [31:0] raw;
        raw = value * ppd_divisor();
        trk_acc = cfg_swap ? -raw : raw;
        trk_base = trk_acc[15:0];
        trk_shown = clamped_detents();
        trk_flags = '0;
        return trk_base;
    endfunction

    // apply one accepted command word and queue the report it should give
    function automatic void advance_detent_tracker(input t_tracker_cmd c);
        t_tracker_report r;
        logic signed [31:0] now_count;
        logic up;
        r.changed = 1'b0;
        r.load = 1'b0;
        r.load_value = '0;
        cmd_seen[c.cmd]++;
        case (c.cmd)
            CMD_POLL: begin
                take_counter(c.sample);
                now_count = clamped_detents();
                if (now_count != trk_shown) begin
                    up = now_count > trk_shown;
                    trk_flags[FLAG_CHANGED] = 1'b1;
                    if (up) trk_flags[FLAG_UP] = 1'b1;
                    else trk_flags[FLAG_DOWN] = 1'b1;
                    trk_dir = up ? DIR_UP : DIR_DOWN;
                    trk_tick = c.tick;
                    trk_shown = now_count;
                    r.changed = 1'b1;
                    count_changes++;
                end
            end
            CMD_SET: begin
                r.load_value = reload_count(c.operand);
                r.load = 1'b1;
            end
            CMD_ADD: begin
                take_counter(c.sample);
                now_count = clamped_detents();
                r.load_value = reload_count(now_count + c.operand);
                r.load = 1'b1;
            end
            CMD_INVERT: begin
                take_counter(c.sample);
                now_count = clamped_detents();
                r.load_value = reload_count(-now_count);
                r.load = 1'b1;
            end
            CMD_RESET_MIN: begin
                r.load_value = reload_count(cfg_min);
                r.load = 1'b1;
            end
            CMD_RESTART: begin
                trk_acc = '0;
                trk_base = '0;
                trk_flags = '0;
                trk_dir = DIR_NONE;
                trk_tick = '0;
                trk_shown = clamped_detents();
                r.load = 1'b1;
            end
            default: begin
                // spare codes leave the state alone
            end
        endcase
        r.count = clamped_detents();
        r.position = shown_position();
        r.flags = trk_flags;
        r.dir = trk_dir;
        r.tick = trk_tick;
        expected_reports.push_back(r);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // input side: present words from the pending queue, gaps at random
    always @(posedge i_clk) begin : drive_words
        t_tracker_cmd next_cmd;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_detent_tracker(held_cmd);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
                    next_cmd = pending_cmds.pop_front();
                    held_cmd <= next_cmd;
                    s_axis_tdata <= {next_cmd.tick, next_cmd.operand, next_cmd.sample};
                    s_axis_tuser <= next_cmd.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: random stalls, compare every accepted word
    always @(posedge i_clk) begin : check_reports
        t_tracker_report want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected report, expected none actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("detent_count", want.count, m_axis_tdata[31:0]);
                    compare_field("pulse_position", want.position, m_axis_tdata[63:32]);
                    compare_field("count_changed", 32'(want.changed), 32'(m_axis_tdata[64]));
                    compare_field("event_flags", 32'(want.flags), 32'(m_axis_tdata[67:65]));
                    compare_field("last_direction", 32'(want.dir), 32'(m_axis_tdata[69:68]));
                    compare_field("activity_tick", want.tick, m_axis_tdata[101:70]);
                    compare_field("counter_load", 32'(want.load), 32'(m_axis_tdata[102]));
                    compare_field("counter_load_value", 32'(want.load_value),
                                  32'(m_axis_tdata[118:103]));
                    compare_field("pad", 32'd0, 32'(m_axis_tdata[119]));
                end
            end
            m_axis_tready <= ($urandom_range(99, 0) >= recv_gap_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [15:0] sample,
                             input logic [31:0] operand, input logic [31:0] tick);
        t_tracker_cmd c;
        c.cmd = cmd;
        c.sample = sample;
        c.operand = operand;
        c.tick = tick;
        pending_cmds.push_back(c);
        cmds_issued++;
    endtask

    // block until every queued word has come back
    task automatic wait_for_drain();
        while (results_seen < cmds_issued) @(posedge i_clk);
    endtask

    task automatic write_tracker_reg(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_PPD:  cfg_ppd = value[7:0];
            REG_SWAP: cfg_swap = value[0];
            REG_MIN:  cfg_min = value;
            REG_MAX:  cfg_max = value;
            default:  ;
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] ppd, input logic [31:0] swap,
                                  input logic [31:0] lo, input logic [31:0] hi);
        write_tracker_reg(REG_PPD, ppd);
        write_tracker_reg(REG_SWAP, swap);
        write_tracker_reg(REG_MIN, lo);
        write_tracker_reg(REG_MAX, hi);
    endtask

    // register settings for the random part, extremes included
    task automatic apply_setting(input int which);
        case (which)
            0: write_all_regs(32'd1, 32'd0, MIN_RESET, MAX_RESET);
            1: write_all_regs(32'd255, 32'd1, -32'sd3, 32'sd7);
            2: write_all_regs(32'd0, 32'd1, MIN_RESET, MAX_RESET);
            3: write_all_regs($urandom_range(255, 1), $urandom_range(1, 0),
                              -32'($urandom_range(100, 0)), 32'($urandom_range(100, 0)));
            4: write_all_regs(32'd4, 32'd0, 32'sd20, -32'sd20);
            default: write_all_regs($urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5, 0))
            0, 1:    return $urandom;
            2:       return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(40, 0)) - 32'd20;
        endcase
    endfunction

    // next encoder reading: mostly small steps, some wrap-sized leaps and noise
    task automatic step_encoder();
        case ($urandom_range(19, 0))
            0:       stim_counter = $urandom;
            1:       stim_counter = stim_counter + 16'($urandom_range(WRAP_HALF, 32000));
            2:       stim_counter = stim_counter - 16'($urandom_range(WRAP_HALF, 32000));
            3:       stim_counter = stim_counter + 16'($urandom_range(1200, 0)) - 16'd600;
            default: stim_counter = stim_counter + 16'($urandom_range(24, 0)) - 16'd12;
        endcase
        if ($urandom_range(30, 0) == 0) stim_tick = $urandom;
        else stim_tick = stim_tick + $urandom_range(80, 1);
    endtask

    // a run of polls while the knob turns, closed by one more command, which may be another poll
    task automatic queue_motion_run(input int polls);
        int k;
        logic [CMD_W-1:0] closer;
        for (k = 0; k < polls; k++) begin
            step_encoder();
            queue_cmd(CMD_POLL, stim_counter, $urandom, stim_tick);
        end
        case ($urandom_range(13, 0))
            0, 1:    closer = CMD_SET;
            2, 3, 4: closer = CMD_ADD;
            5, 6:    closer = CMD_INVERT;
            7, 8:    closer = CMD_RESET_MIN;
            9, 10:   closer = CMD_RESTART;
            11:      closer = CMD_SPARE_6;
            12:      closer = CMD_SPARE_7;
            default: closer = CMD_POLL;
        endcase
        step_encoder();
        queue_cmd(closer, stim_counter, pick_operand(), stim_tick);
    endtask

    initial begin
        int profile;
        int pass;
        int target;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct = 22;
        recv_gap_pct = 71;

        // directed words at reset settings, four pulses per detent
        queue_cmd(CMD_RESTART, 16'h1234, 32'h0, 32'd5);
        queue_cmd(CMD_POLL, 16'h0004, 32'h0, 32'hFFFF_FFFF);
        queue_cmd(CMD_POLL, 16'hFFFC, 32'h0, 32'h0);
        queue_cmd(CMD_POLL, 16'h7FFF, 32'h0, 32'd10);   // wraps negative
        queue_cmd(CMD_POLL, 16'h8000, 32'h0, 32'd11);   // wraps by one
        queue_cmd(CMD_POLL, 16'h0000, 32'h0, 32'd12);   // half span exactly
        queue_cmd(CMD_POLL, 16'h7FFF, 32'h0, 32'd13);   // largest step with no wrap
        queue_cmd(CMD_POLL, 16'h0000, 32'h0, 32'd14);   // largest step down
        queue_cmd(CMD_SET, 16'hFFFF, 32'h7FFF_FFFF, 32'd15);
        queue_cmd(CMD_SET, 16'h0000, 32'h8000_0000, 32'd16);
        queue_cmd(CMD_ADD, 16'h0010, 32'h7FFF_FFFF, 32'd17);
        queue_cmd(CMD_INVERT, 16'hFFFF, 32'h0, 32'd18);
        queue_cmd(CMD_RESET_MIN, 16'h5555, 32'h0, 32'd19);
        queue_cmd(CMD_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_SPARE_7, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        wait_for_drain();

        // zero divisor acts as one, swapped sense, tight clamps
        write_all_regs(32'd0, 32'd1, -32'sd5, 32'sd5);
        queue_cmd(CMD_SET, 16'hFFFF, 32'd100, 32'd20);
        queue_cmd(CMD_POLL, 16'h0100, 32'h0, 32'd21);
        queue_cmd(CMD_SET, 16'h0000, 32'h8000_0000, 32'd22);
        queue_cmd(CMD_INVERT, 16'h0000, 32'h0, 32'd23);
        queue_cmd(CMD_ADD, 16'h0003, 32'hFFFF_FFFF, 32'd24);
        queue_cmd(CMD_RESET_MIN, 16'h0000, 32'h0, 32'd25);
        queue_cmd(CMD_RESTART, 16'h0000, 32'h0, 32'd26);
        wait_for_drain();

        // crossed clamps, widest divisor
        write_all_regs(32'd255, 32'd0, 32'sd3, -32'sd3);
        queue_cmd(CMD_POLL, 16'h0400, 32'h0, 32'd27);
        queue_cmd(CMD_ADD, 16'h0400, 32'h8000_0000, 32'd28);
        queue_cmd(CMD_POLL, 16'hF000, 32'h0, 32'd29);
        wait_for_drain();
        stim_counter = trk_base;
        stim_tick = 32'd100;

        // random motion: three stall mixes, two settings each
        for (profile = 0; profile < 3; profile++) begin
            send_gap_pct = (profile == 0) ? 22 : (profile == 1) ? 71 : 0;
            recv_gap_pct = (profile == 0) ? 71 : (profile == 1) ? 22 : 0;
            for (pass = 0; pass < 2; pass++) begin
                wait_for_drain();
                apply_setting(profile * 2 + pass);
                stim_counter = trk_base;
                target = cmds_issued + 130;
                while (cmds_issued < target) begin
                    queue_motion_run($urandom_range(20, 3));
                    // hold the input until all reports are back, then follow the reload
                    if ($urandom_range(1, 0) == 1) begin
                        wait_for_drain();
                        stim_counter = trk_base;
                    end
                end
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("commands: poll %0d, set %0d, add %0d, invert %0d, reset-min %0d,",
                 cmd_seen[CMD_POLL], cmd_seen[CMD_SET], cmd_seen[CMD_ADD],
                 cmd_seen[CMD_INVERT], cmd_seen[CMD_RESET_MIN]);
        $display("  restart %0d, spare %0d; %0d reports checked, %0d count changes,",
                 cmd_seen[CMD_RESTART], cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7],
                 results_seen, count_changes);
        $display("  %0d register writes, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/redt_pkg.sv
rtl/core/redt_div.sv
rtl/core/rotary_encoder_detent_tracker_top.sv
verif/tb_rotary_encoder_detent_tracker_top.sv
